>>> design/alx_pkg.sv
// Shared types and constants for the assembly line lexer.
package alx_pkg;

    // Value buffer depth and derived widths
    localparam int MAX_VALUE_LEN = 32;
    localparam int LEN_W         = $clog2(MAX_VALUE_LEN + 1);
    localparam int ADDR_W        = $clog2(MAX_VALUE_LEN);

    // Token kinds as they appear on the result channel
    typedef enum logic [2:0] {
        K_ADDRESS = 3'd0,
        K_EQUALS  = 3'd1,
        K_LABEL   = 3'd2,
        K_SEMI    = 3'd3,
        K_COMP    = 3'd4,
        K_ERROR   = 3'd5
    } kind_t;

    // One input request
    typedef struct packed {
        logic [7:0] character;
        logic       end_of_input;
    } char_item_t;

    // One result request
    typedef struct packed {
        logic [2:0] token_kind;
        logic [7:0] value_char;
        logic       value_empty;
        logic       value_overflow;
        logic       token_last;
        logic       step_last;
    } token_item_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic  capture;
        logic  clear;
        logic  append;
        logic  restart;
        logic  rd_reset;
        logic  rd_issue;
        logic  rd_advance;
        logic  load_buf;
        logic  load_single;
        kind_t kind;
        logic  step_last;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_digit;
        logic is_symbol;
        logic is_name;
        logic is_compute;
        logic is_space;
        logic is_at;
        logic is_equals;
        logic is_lparen;
        logic is_rparen;
        logic is_semi;
        logic eoi;
        logic rd_last;
        logic out_free;
    } dp_status_t;

endpackage

>>> design/alx_datapath.sv
// Datapath: input capture, character classes, value buffer and result register.
module alx_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  alx_pkg::char_item_t char_item,
    input  logic                token_stall,
    output logic                token_valid,
    output alx_pkg::token_item_t token_item,
    input  alx_pkg::dp_cmd_t    cmd,
    output alx_pkg::dp_status_t status
);

    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [alx_pkg::LEN_W-1:0] MAX_LEN = alx_pkg::LEN_W'(alx_pkg::MAX_VALUE_LEN);

    logic [7:0]                 char_reg;
    logic                       eoi_reg;
    logic [7:0]                 mem [alx_pkg::MAX_VALUE_LEN];
    logic [7:0]                 rd_data_reg;
    logic [alx_pkg::LEN_W-1:0]  length_reg;
    logic [alx_pkg::LEN_W-1:0]  length_next;
    logic                       ovf_reg;
    logic                       ovf_next;
    logic [alx_pkg::LEN_W-1:0]  idx_reg;
    logic [alx_pkg::LEN_W-1:0]  idx_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    alx_pkg::token_item_t       out_item_reg;
    logic                       wr_en;
    logic [alx_pkg::ADDR_W-1:0] wr_addr;
    logic                       room;
    logic                       is_letter;
    logic [7:0]                 single_char;

    // Hold the accepted request
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            char_reg <= char_item.character;
            eoi_reg  <= char_item.end_of_input;
        end
    end

    // Classify the held character
    always_comb
    begin
        is_letter        = (char_reg >= 8'h61 && char_reg <= 8'h7A) ||
                           (char_reg >= 8'h41 && char_reg <= 8'h5A);
        status.is_digit  = char_reg >= 8'h30 && char_reg <= 8'h39;
        status.is_symbol = is_letter || char_reg == CH_DOLLAR || char_reg == CH_UNDER ||
                           char_reg == CH_COLON || char_reg == CH_DOT;
        status.is_name   = status.is_symbol || status.is_digit;
        status.is_compute = status.is_name || char_reg == CH_MINUS || char_reg == CH_PLUS ||
                            char_reg == CH_BANG || char_reg == CH_AMP || char_reg == CH_BAR;
        status.is_space  = char_reg == CH_SPACE || char_reg == CH_NL;
        status.is_at     = char_reg == CH_AT;
        status.is_equals = char_reg == CH_EQ;
        status.is_lparen = char_reg == CH_LPAREN;
        status.is_rparen = char_reg == CH_RPAREN;
        status.is_semi   = char_reg == CH_SEMI;
        status.eoi       = eoi_reg;
        status.rd_last   = length_reg == '0 ||
                           (idx_reg + alx_pkg::LEN_W'(1)) == length_reg;
        status.out_free  = !out_valid_reg || !token_stall;
    end

    // Update buffer length and overflow mark
    always_comb
    begin
        room        = length_reg < MAX_LEN;
        length_next = length_reg;
        ovf_next    = ovf_reg;
        wr_en       = 1'b0;
        wr_addr     = length_reg[alx_pkg::ADDR_W-1:0];
        if (cmd.restart)
        begin
            wr_en       = 1'b1;
            wr_addr     = '0;
            length_next = alx_pkg::LEN_W'(1);
            ovf_next    = 1'b0;
        end
        else if (cmd.clear)
        begin
            length_next = '0;
            ovf_next    = 1'b0;
        end
        else if (cmd.append)
        begin
            if (room)
            begin
                wr_en       = 1'b1;
                length_next = length_reg + alx_pkg::LEN_W'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    // Advance the read index
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.rd_reset)
        begin
            idx_next = '0;
        end
        else if (cmd.rd_advance)
        begin
            idx_next = idx_reg + alx_pkg::LEN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg    <= '0;
            ovf_reg       <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            length_reg    <= length_next;
            ovf_reg       <= ovf_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Write and read the value buffer
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= char_reg;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= mem[idx_reg[alx_pkg::ADDR_W-1:0]];
        end
    end

    // Load the result register
    always_comb
    begin
        case (cmd.kind)
            alx_pkg::K_EQUALS: single_char = CH_EQ;
            alx_pkg::K_SEMI:   single_char = CH_SEMI;
            default:           single_char = CH_QUEST;
        endcase
        out_valid_next = out_valid_reg && token_stall;
        if (cmd.load_buf || cmd.load_single)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_buf)
        begin
            out_item_reg.token_kind     <= cmd.kind;
            out_item_reg.value_char     <= (length_reg == '0) ? 8'h00 : rd_data_reg;
            out_item_reg.value_empty    <= length_reg == '0;
            out_item_reg.value_overflow <= ovf_reg;
            out_item_reg.token_last     <= status.rd_last;
            out_item_reg.step_last      <= cmd.step_last;
        end
        else if (cmd.load_single)
        begin
            out_item_reg.token_kind     <= cmd.kind;
            out_item_reg.value_char     <= single_char;
            out_item_reg.value_empty    <= 1'b0;
            out_item_reg.value_overflow <= 1'b0;
            out_item_reg.token_last     <= 1'b1;
            out_item_reg.step_last      <= cmd.step_last;
        end
    end

    assign token_valid = out_valid_reg;
    assign token_item  = out_item_reg;

    // The buffer never holds more than its depth
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        length_reg <= MAX_LEN)
        else $error("value length beyond buffer depth");

    // Never load over a result that is still stalled
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_buf || cmd.load_single) |-> status.out_free)
        else $error("result register overwritten while stalled");

    // Only one source loads the result register at a time
    a_load_one: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load_buf && cmd.load_single))
        else $error("two result loads in one cycle");

    // A buffer read is always followed by a load or wait cycle, never a second read
    a_rd_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_issue |=> !cmd.rd_issue)
        else $error("buffer reads issued back to back");

endmodule

>>> design/alx_ctrl.sv
// Controller: lexer mode and step sequencer.
module alx_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                char_valid,
    output logic                char_stall,
    input  alx_pkg::dp_status_t status,
    output alx_pkg::dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        M_IDLE, M_AT, M_ANUM, M_ASYM, M_PAREN, M_LABEL, M_COMP
    } mode_t;

    typedef enum logic [2:0] {
        S_WAIT, S_DECODE, S_RD, S_OUT, S_SINGLE
    } state_t;

    typedef enum logic [2:0] {
        T_NONE, T_CLEAR, T_APPEND, T_RESTART, T_SINGLE
    } tail_t;

    typedef struct packed {
        tail_t          tail;
        alx_pkg::kind_t single;
        mode_t          mode;
    } plan_t;

    state_t         st_reg, st_next;
    mode_t          mode_reg, mode_next;
    alx_pkg::kind_t flush_kind_reg, flush_kind_next;
    plan_t          plan_reg, plan_next;
    logic           p_flush;
    alx_pkg::kind_t p_kind;
    plan_t          p_plan;

    // Plan for a character seen from idle
    function automatic plan_t idle_plan(alx_pkg::dp_status_t s);
        plan_t p;
        p.tail   = T_NONE;
        p.single = alx_pkg::K_ERROR;
        p.mode   = M_IDLE;
        if (s.is_space)
        begin
            p.tail = T_NONE;
        end
        else if (s.is_at)
        begin
            p.tail = T_CLEAR;
            p.mode = M_AT;
        end
        else if (s.is_equals)
        begin
            p.tail   = T_SINGLE;
            p.single = alx_pkg::K_EQUALS;
        end
        else if (s.is_lparen)
        begin
            p.tail = T_CLEAR;
            p.mode = M_PAREN;
        end
        else if (s.is_semi)
        begin
            p.tail   = T_SINGLE;
            p.single = alx_pkg::K_SEMI;
        end
        else if (s.is_compute)
        begin
            p.tail = T_RESTART;
            p.mode = M_COMP;
        end
        else
        begin
            p.tail = T_SINGLE;
        end
        return p;
    endfunction

    // Plan after an unclosed label: computation or error
    function automatic plan_t label_break_plan(alx_pkg::dp_status_t s);
        plan_t p;
        p.single = alx_pkg::K_ERROR;
        if (s.is_compute)
        begin
            p.tail = T_RESTART;
            p.mode = M_COMP;
        end
        else
        begin
            p.tail = T_SINGLE;
            p.mode = M_IDLE;
        end
        return p;
    endfunction

    function automatic plan_t keep(mode_t m);
        plan_t p;
        p.tail   = T_APPEND;
        p.single = alx_pkg::K_ERROR;
        p.mode   = m;
        return p;
    endfunction

    // Decode the held character against the current mode
    always_comb
    begin
        p_flush = 1'b0;
        p_kind  = alx_pkg::K_ADDRESS;
        p_plan  = idle_plan(status);
        if (status.eoi)
        begin
            p_flush       = mode_reg inside {M_AT, M_ANUM, M_ASYM, M_COMP};
            p_kind        = (mode_reg == M_COMP) ? alx_pkg::K_COMP : alx_pkg::K_ADDRESS;
            p_plan.tail   = T_SINGLE;
            p_plan.single = alx_pkg::K_ERROR;
            p_plan.mode   = M_IDLE;
        end
        else
        begin
            case (mode_reg)
                M_AT:
                begin
                    if (status.is_digit)
                        p_plan = keep(M_ANUM);
                    else if (status.is_symbol)
                        p_plan = keep(M_ASYM);
                    else
                        p_flush = 1'b1;
                end
                M_ANUM:
                begin
                    if (status.is_digit)
                        p_plan = keep(M_ANUM);
                    else
                        p_flush = 1'b1;
                end
                M_ASYM:
                begin
                    if (status.is_name)
                        p_plan = keep(M_ASYM);
                    else
                        p_flush = 1'b1;
                end
                M_PAREN, M_LABEL:
                begin
                    if ((mode_reg == M_PAREN) ? status.is_symbol : status.is_name)
                    begin
                        p_plan = keep(M_LABEL);
                    end
                    else if (status.is_rparen)
                    begin
                        p_flush     = 1'b1;
                        p_kind      = alx_pkg::K_LABEL;
                        p_plan.tail = T_NONE;
                        p_plan.mode = M_IDLE;
                    end
                    else
                    begin
                        p_plan = label_break_plan(status);
                    end
                end
                M_COMP:
                begin
                    p_kind = alx_pkg::K_COMP;
                    if (status.is_compute)
                        p_plan = keep(M_COMP);
                    else
                        p_flush = 1'b1;
                end
                default:
                begin
                    p_plan = idle_plan(status);
                end
            endcase
        end
    end

    // Sequence the step and drive datapath commands
    always_comb
    begin
        st_next         = st_reg;
        mode_next       = mode_reg;
        flush_kind_next = flush_kind_reg;
        plan_next       = plan_reg;
        cmd             = '0;
        cmd.kind        = alx_pkg::K_ERROR;
        case (st_reg)
            S_WAIT:
            begin
                cmd.capture = char_valid;
                if (char_valid)
                    st_next = S_DECODE;
            end
            S_DECODE:
            begin
                flush_kind_next = p_kind;
                plan_next       = p_plan;
                if (p_flush)
                begin
                    cmd.rd_reset = 1'b1;
                    st_next      = S_RD;
                end
                else if (p_plan.tail == T_SINGLE)
                begin
                    st_next = S_SINGLE;
                end
                else
                begin
                    cmd.clear   = p_plan.tail == T_CLEAR;
                    cmd.append  = p_plan.tail == T_APPEND;
                    cmd.restart = p_plan.tail == T_RESTART;
                    mode_next   = p_plan.mode;
                    st_next     = S_WAIT;
                end
            end
            S_RD:
            begin
                cmd.rd_issue = 1'b1;
                st_next      = S_OUT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_buf  = 1'b1;
                    cmd.kind      = flush_kind_reg;
                    cmd.step_last = status.rd_last && plan_reg.tail != T_SINGLE;
                    if (status.rd_last)
                    begin
                        cmd.clear = 1'b1;
                        if (plan_reg.tail == T_SINGLE)
                        begin
                            st_next = S_SINGLE;
                        end
                        else
                        begin
                            cmd.restart = plan_reg.tail == T_RESTART;
                            mode_next   = plan_reg.mode;
                            st_next     = S_WAIT;
                        end
                    end
                    else
                    begin
                        cmd.rd_advance = 1'b1;
                        st_next        = S_RD;
                    end
                end
            end
            S_SINGLE:
            begin
                if (status.out_free)
                begin
                    cmd.load_single = 1'b1;
                    cmd.kind        = plan_reg.single;
                    cmd.step_last   = 1'b1;
                    cmd.clear       = 1'b1;
                    mode_next       = plan_reg.mode;
                    st_next         = S_WAIT;
                end
            end
            default:
            begin
                st_next = S_WAIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= S_WAIT;
            mode_reg       <= M_IDLE;
            flush_kind_reg <= alx_pkg::K_ADDRESS;
            plan_reg       <= '{tail: T_NONE, single: alx_pkg::K_ERROR, mode: M_IDLE};
        end
        else
        begin
            st_reg         <= st_next;
            mode_reg       <= mode_next;
            flush_kind_reg <= flush_kind_next;
            plan_reg       <= plan_next;
        end
    end

    assign char_stall = st_reg != S_WAIT;

    // An accepted request is always decoded next
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && !char_stall) |=> st_reg == S_DECODE)
        else $error("accepted request not decoded");

    // End of input always leaves the lexer idle
    a_eoi_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_DECODE && status.eoi) |-> plan_next.mode == M_IDLE)
        else $error("end of input does not return to idle");

    // The final result of a step hands the line back to the input side
    a_step_end: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_buf && cmd.step_last) |=> st_reg == S_WAIT)
        else $error("step ended without returning to wait");

endmodule

>>> design/assembly_line_lexer.sv
// Top level of the assembly line lexer: controller plus datapath.
//
//  channel  valid        stall        payload
//  input    char_valid   char_stall   char_item  (character, end_of_input)
//  result   token_valid  token_stall  token_item (kind, char, flags)
//
// A character that yields no result is only accepted and decoded.
// A flushed token reads each buffered character from the value buffer and
// then loads it into the result register (an empty value gets one read and
// load), followed by a load for a trailing single-character token, if any.
// Reset is asynchronous and active low; the buffer needs no clearing pass.
// A stalled result holds the sequencer; char_stall stays high until the step ends.
module assembly_line_lexer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 char_valid,
    output logic                 char_stall,
    input  alx_pkg::char_item_t  char_item,
    output logic                 token_valid,
    input  logic                 token_stall,
    output alx_pkg::token_item_t token_item
);

    alx_pkg::dp_cmd_t    cmd;
    alx_pkg::dp_status_t status;

    alx_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .status     (status),
        .cmd        (cmd)
    );

    alx_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_item   (char_item),
        .token_stall (token_stall),
        .token_valid (token_valid),
        .token_item  (token_item),
        .cmd         (cmd),
        .status      (status)
    );

endmodule
